[hw/rtl/bmp32pm_pkg.sv]
// ----------------------------------------------------------------------------
// bmp32pm_pkg: shared types and constants for the 32-bpp BMP premultiplier
// Word formats, header field offsets, image geometry and the premultiply
// arithmetic used by the parser front end and the pixel back end.
// ----------------------------------------------------------------------------
package bmp32pm_pkg;

  // Fixed image geometry
  localparam int IMG_WIDTH  = 160;
  localparam int IMG_HEIGHT = 160;
  localparam int COL_W = (IMG_WIDTH  > 1) ? $clog2(IMG_WIDTH)  : 1;
  localparam int ROW_W = (IMG_HEIGHT > 1) ? $clog2(IMG_HEIGHT) : 1;

  // Header layout (byte offsets within the file)
  localparam int HDR_LEN     = 54;
  localparam int OFS_SIG0    = 0;
  localparam int OFS_SIG1    = 1;
  localparam int OFS_PIX     = 10;
  localparam int OFS_WIDTH   = 18;
  localparam int OFS_HEIGHT  = 22;
  localparam int OFS_PLANES  = 26;
  localparam int OFS_BPP     = 28;
  localparam int OFS_COMP    = 30;
  localparam int OFS_END     = 34;

  localparam logic [7:0]  SIG_B        = 8'h42;
  localparam logic [7:0]  SIG_M        = 8'h4D;
  localparam logic [15:0] GOOD_PLANES  = 16'd1;
  localparam logic [15:0] GOOD_BPP     = 16'd32;
  localparam logic [31:0] POS_MAX      = 32'hFFFF_FFFF;
  localparam logic [31:0] POS_HEIGHT   = 32'(IMG_HEIGHT);
  localparam logic [31:0] NEG_HEIGHT   = 32'd0 - 32'(IMG_HEIGHT);

  // Result kinds
  localparam logic [1:0] KIND_PIXEL   = 2'd0;
  localparam logic [1:0] KIND_BAD_SIG = 2'd1;
  localparam logic [1:0] KIND_BAD_GEO = 2'd2;
  localparam logic [1:0] KIND_BAD_OFS = 2'd3;

  // Queue between parser and pixel unit
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_IDLE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] alpha_out;
    logic [7:0] dest_row;
    logic [7:0] dest_col;
    logic       last;
  } out_word_t;

  // Classified work item: raw colour bytes, not yet premultiplied
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] raw0;
    logic [7:0] raw1;
    logic [7:0] raw2;
    logic [7:0] alpha;
    logic [7:0] dest_row;
    logic [7:0] dest_col;
    logic       last;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  // c*a/255 rounded: p = c*a + 128, (p + (p >> 8)) >> 8
  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] p;
    logic [15:0] s;
    p = 16'(c) * 16'(a) + 16'd128;
    s = p + {8'd0, p[15:8]};
    return s[15:8];
  endfunction

endpackage

[hw/rtl/bmp32_premultiply_stream_top.sv]
// ----------------------------------------------------------------------------
// bmp32_premultiply_stream_top: streaming 32-bpp BMP parser and premultiplier
// Parses and checks the BMP header, skips to the pixel data and emits one
// alpha-premultiplied word per pixel with its destination row and column.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_word  (data_byte, start_of_file)
//   out_     output     out_valid / out_stall out_word (kind, chan0..2, alpha_out,
//                                                      dest_row, dest_col, last)
//
// One file byte is taken per cycle while in_stall is low; a pixel word is
// produced for every fourth byte of pixel data, and header errors give a
// single error word. After its final byte is taken, a job is written into
// the queue, then moves through the premultiply stage into the output
// register that drives out_.
// in_stall rises only when the four-entry job queue is full, which happens
// when out_stall has held back results for several pixels.
// rst_n is synchronous and active low; after reset the next byte is parsed
// as header byte 0 of a new file, with or without start_of_file.
// ----------------------------------------------------------------------------
module bmp32_premultiply_stream_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  bmp32pm_pkg::in_word_t  in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output bmp32pm_pkg::out_word_t out_word
);

  // Front end to queue: push strobe plus classified job
  bmp32pm_pkg::q_wr_t q_wr;
  logic               q_full;

  // Queue to back end
  logic               q_valid;
  logic               q_pop;
  bmp32pm_pkg::job_t  q_job;

  // Parse header, track position, gather pixel bytes
  bmp32pm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  // Decouple the byte side from output backpressure
  bmp32pm_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_job   (q_job)
  );

  // Premultiply and hold the result word
  bmp32pm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

[hw/rtl/bmp32pm_front.sv]
// ----------------------------------------------------------------------------
// bmp32pm_front: header parser and pixel gatherer
// Tracks the file position, collects and checks the header, gathers pixel
// bytes and pushes one classified job per result into the queue.
// ----------------------------------------------------------------------------
module bmp32pm_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bmp32pm_pkg::in_word_t in_word,
  input  logic                  q_full,
  output bmp32pm_pkg::q_wr_t    q_wr
);

  logic                      accept;
  logic                      sof;
  logic [7:0]                dbyte;

  logic [31:0]               pos_r, pos_nxt;
  bmp32pm_pkg::phase_t       phase_r, phase_nxt;
  logic [31:0]               pix_start_r, pix_start_nxt;
  logic [7:0]                sig0_r, sig0_nxt;
  logic [7:0]                sig1_r, sig1_nxt;
  logic [31:0]               width_r, width_nxt;
  logic [31:0]               height_r, height_nxt;
  logic [15:0]               planes_r, planes_nxt;
  logic [15:0]               bpp_r, bpp_nxt;
  logic [31:0]               comp_r, comp_nxt;
  logic                      bottom_up_r, bottom_up_nxt;
  logic [23:0]               pix_bytes_r, pix_bytes_nxt;
  logic [1:0]                lane_r, lane_nxt;
  logic [bmp32pm_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [bmp32pm_pkg::COL_W-1:0] col_r, col_nxt;

  // State as seen by this byte: a start of file clears everything first
  logic [31:0]               b_pos;
  bmp32pm_pkg::phase_t       b_phase;
  logic [31:0]               b_pix_start;
  logic [7:0]                b_sig0, b_sig1;
  logic [31:0]               b_width, b_height, b_comp;
  logic [15:0]               b_planes, b_bpp;
  logic                      b_bottom_up;
  logic [23:0]               b_pix_bytes;
  logic [1:0]                b_lane;
  logic [bmp32pm_pkg::ROW_W-1:0] b_row;
  logic [bmp32pm_pkg::COL_W-1:0] b_col;

  logic [5:0]                hdr_idx;
  logic [1:0]                hlane;
  logic                      hdr_end;
  logic                      sig_bad, geo_bad, ofs_bad;
  logic                      in_window;
  logic                      fin;
  logic [bmp32pm_pkg::ROW_W-1:0] row_sel;

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;
  assign sof      = in_word.start_of_file;
  assign dbyte    = in_word.data_byte;

  assign b_pos       = sof ? '0 : pos_r;
  assign b_phase     = sof ? bmp32pm_pkg::PH_HEADER : phase_r;
  assign b_pix_start = sof ? '0 : pix_start_r;
  assign b_sig0      = sof ? '0 : sig0_r;
  assign b_sig1      = sof ? '0 : sig1_r;
  assign b_width     = sof ? '0 : width_r;
  assign b_height    = sof ? '0 : height_r;
  assign b_planes    = sof ? '0 : planes_r;
  assign b_bpp       = sof ? '0 : bpp_r;
  assign b_comp      = sof ? '0 : comp_r;
  assign b_bottom_up = sof ? 1'b0 : bottom_up_r;
  assign b_pix_bytes = sof ? '0 : pix_bytes_r;
  assign b_lane      = sof ? '0 : lane_r;
  assign b_row       = sof ? '0 : row_r;
  assign b_col       = sof ? '0 : col_r;

  // Header phase never runs past byte 53, so six bits cover the index
  assign hdr_idx = b_pos[5:0];
  assign hdr_end = (b_phase == bmp32pm_pkg::PH_HEADER) &&
                   (hdr_idx == 6'(bmp32pm_pkg::HDR_LEN - 1));

  assign sig_bad = (b_sig0 != bmp32pm_pkg::SIG_B) || (b_sig1 != bmp32pm_pkg::SIG_M);
  assign geo_bad = (b_width != 32'(bmp32pm_pkg::IMG_WIDTH)) ||
                   ((b_height != bmp32pm_pkg::POS_HEIGHT) &&
                    (b_height != bmp32pm_pkg::NEG_HEIGHT)) ||
                   (b_planes != bmp32pm_pkg::GOOD_PLANES) ||
                   (b_bpp != bmp32pm_pkg::GOOD_BPP) || (b_comp != '0);
  assign ofs_bad = b_pix_start < 32'(bmp32pm_pkg::HDR_LEN);

  assign in_window = b_pos >= b_pix_start;
  assign fin = (b_row == bmp32pm_pkg::ROW_W'(bmp32pm_pkg::IMG_HEIGHT - 1)) &&
               (b_col == bmp32pm_pkg::COL_W'(bmp32pm_pkg::IMG_WIDTH - 1));
  assign row_sel = b_bottom_up ?
                   bmp32pm_pkg::ROW_W'(bmp32pm_pkg::IMG_HEIGHT - 1) - b_row : b_row;

  // Next state
  always_comb begin
    pos_nxt       = (b_pos == bmp32pm_pkg::POS_MAX) ? b_pos : b_pos + 32'd1;
    phase_nxt     = b_phase;
    pix_start_nxt = b_pix_start;
    sig0_nxt      = b_sig0;
    sig1_nxt      = b_sig1;
    width_nxt     = b_width;
    height_nxt    = b_height;
    planes_nxt    = b_planes;
    bpp_nxt       = b_bpp;
    comp_nxt      = b_comp;
    bottom_up_nxt = b_bottom_up;
    pix_bytes_nxt = b_pix_bytes;
    lane_nxt      = b_lane;
    row_nxt       = b_row;
    col_nxt       = b_col;
    hlane         = '0;
    case (b_phase)
      bmp32pm_pkg::PH_HEADER: begin
        if (hdr_idx == 6'(bmp32pm_pkg::OFS_SIG0)) begin
          sig0_nxt = dbyte;
        end else if (hdr_idx == 6'(bmp32pm_pkg::OFS_SIG1)) begin
          sig1_nxt = dbyte;
        end else if (hdr_idx >= 6'(bmp32pm_pkg::OFS_PIX) &&
                     hdr_idx < 6'(bmp32pm_pkg::OFS_PIX + 4)) begin
          hlane = 2'(hdr_idx - 6'(bmp32pm_pkg::OFS_PIX));
          pix_start_nxt[{hlane, 3'b000} +: 8] = dbyte;
        end else if (hdr_idx >= 6'(bmp32pm_pkg::OFS_WIDTH) &&
                     hdr_idx < 6'(bmp32pm_pkg::OFS_HEIGHT)) begin
          hlane = 2'(hdr_idx - 6'(bmp32pm_pkg::OFS_WIDTH));
          width_nxt[{hlane, 3'b000} +: 8] = dbyte;
        end else if (hdr_idx >= 6'(bmp32pm_pkg::OFS_HEIGHT) &&
                     hdr_idx < 6'(bmp32pm_pkg::OFS_PLANES)) begin
          hlane = 2'(hdr_idx - 6'(bmp32pm_pkg::OFS_HEIGHT));
          height_nxt[{hlane, 3'b000} +: 8] = dbyte;
        end else if (hdr_idx >= 6'(bmp32pm_pkg::OFS_PLANES) &&
                     hdr_idx < 6'(bmp32pm_pkg::OFS_BPP)) begin
          hlane = 2'(hdr_idx - 6'(bmp32pm_pkg::OFS_PLANES));
          planes_nxt[{hlane[0], 3'b000} +: 8] = dbyte;
        end else if (hdr_idx >= 6'(bmp32pm_pkg::OFS_BPP) &&
                     hdr_idx < 6'(bmp32pm_pkg::OFS_COMP)) begin
          hlane = 2'(hdr_idx - 6'(bmp32pm_pkg::OFS_BPP));
          bpp_nxt[{hlane[0], 3'b000} +: 8] = dbyte;
        end else if (hdr_idx >= 6'(bmp32pm_pkg::OFS_COMP) &&
                     hdr_idx < 6'(bmp32pm_pkg::OFS_END)) begin
          hlane = 2'(hdr_idx - 6'(bmp32pm_pkg::OFS_COMP));
          comp_nxt[{hlane, 3'b000} +: 8] = dbyte;
        end
        if (hdr_end) begin
          if (sig_bad || geo_bad || ofs_bad) begin
            phase_nxt = bmp32pm_pkg::PH_IDLE;
          end else begin
            bottom_up_nxt = (b_height == bmp32pm_pkg::POS_HEIGHT);
            phase_nxt     = bmp32pm_pkg::PH_DATA;
          end
        end
      end
      bmp32pm_pkg::PH_DATA: begin
        if (in_window) begin
          if (b_lane != 2'd3) begin
            pix_bytes_nxt[{b_lane, 3'b000} +: 8] = dbyte;
            lane_nxt = b_lane + 2'd1;
          end else begin
            pix_bytes_nxt = '0;
            lane_nxt      = '0;
            if (b_col == bmp32pm_pkg::COL_W'(bmp32pm_pkg::IMG_WIDTH - 1)) begin
              col_nxt = '0;
              row_nxt = b_row + 1'b1;
            end else begin
              col_nxt = b_col + 1'b1;
            end
            if (fin) begin
              phase_nxt = bmp32pm_pkg::PH_IDLE;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Job output
  always_comb begin
    q_wr = '0;
    if (accept) begin
      case (b_phase)
        bmp32pm_pkg::PH_HEADER: begin
          if (hdr_end && (sig_bad || geo_bad || ofs_bad)) begin
            q_wr.push = 1'b1;
            if (sig_bad) begin
              q_wr.job.kind = bmp32pm_pkg::KIND_BAD_SIG;
            end else if (geo_bad) begin
              q_wr.job.kind = bmp32pm_pkg::KIND_BAD_GEO;
            end else begin
              q_wr.job.kind = bmp32pm_pkg::KIND_BAD_OFS;
            end
          end
        end
        bmp32pm_pkg::PH_DATA: begin
          if (in_window && b_lane == 2'd3) begin
            q_wr.push          = 1'b1;
            q_wr.job.kind      = bmp32pm_pkg::KIND_PIXEL;
            q_wr.job.raw0      = b_pix_bytes[7:0];
            q_wr.job.raw1      = b_pix_bytes[15:8];
            q_wr.job.raw2      = b_pix_bytes[23:16];
            q_wr.job.alpha     = dbyte;
            q_wr.job.dest_row  = 8'(row_sel);
            q_wr.job.dest_col  = 8'(b_col);
            q_wr.job.last      = fin;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      phase_r     <= bmp32pm_pkg::PH_HEADER;
      pix_start_r <= '0;
      sig0_r      <= '0;
      sig1_r      <= '0;
      width_r     <= '0;
      height_r    <= '0;
      planes_r    <= '0;
      bpp_r       <= '0;
      comp_r      <= '0;
      bottom_up_r <= 1'b0;
      pix_bytes_r <= '0;
      lane_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
    end else if (accept) begin
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      pix_start_r <= pix_start_nxt;
      sig0_r      <= sig0_nxt;
      sig1_r      <= sig1_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      planes_r    <= planes_nxt;
      bpp_r       <= bpp_nxt;
      comp_r      <= comp_nxt;
      bottom_up_r <= bottom_up_nxt;
      pix_bytes_r <= pix_bytes_nxt;
      lane_r      <= lane_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
    end
  end

  // The data phase is only entered with a pixel offset past the header
  a_data_offset: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == bmp32pm_pkg::PH_DATA |-> pix_start_r >= 32'(bmp32pm_pkg::HDR_LEN))
    else $error("data phase with pixel offset inside header");

  // Any error job or final pixel closes the file
  a_close_file: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push && (q_wr.job.last || q_wr.job.kind != bmp32pm_pkg::KIND_PIXEL)
    |=> phase_r == bmp32pm_pkg::PH_IDLE)
    else $error("file not closed after error or last pixel");

endmodule

[hw/rtl/bmp32pm_fifo.sv]
// ----------------------------------------------------------------------------
// bmp32pm_fifo: short job queue between parser and pixel unit
// Register-based circular buffer; the head entry is read out directly.
// ----------------------------------------------------------------------------
module bmp32pm_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  bmp32pm_pkg::q_wr_t q_wr,
  output logic               q_full,
  input  logic               q_pop,
  output logic               q_valid,
  output bmp32pm_pkg::job_t  q_job
);

  bmp32pm_pkg::job_t                 mem_r [bmp32pm_pkg::Q_DEPTH];
  logic [bmp32pm_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [bmp32pm_pkg::Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [bmp32pm_pkg::Q_CNT_W-1:0]   count_r, count_nxt;
  logic                              do_push, do_pop;

  assign q_full  = (count_r == bmp32pm_pkg::Q_CNT_W'(bmp32pm_pkg::Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_job   = mem_r[rd_ptr_r];
  assign do_push = q_wr.push && !q_full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == bmp32pm_pkg::Q_PTR_W'(bmp32pm_pkg::Q_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == bmp32pm_pkg::Q_PTR_W'(bmp32pm_pkg::Q_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.job;
    end
  end

  // The parser holds off input while full, so no job is ever dropped
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_wr.push)
    else $error("job pushed into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bmp32pm_pkg::Q_CNT_W'(bmp32pm_pkg::Q_DEPTH))
    else $error("queue count out of range");

endmodule

[hw/rtl/bmp32pm_back.sv]
// ----------------------------------------------------------------------------
// bmp32pm_back: pixel unit and output register
// Premultiplies the colour bytes of a job by alpha and holds the result
// word until the downstream side takes it.
// ----------------------------------------------------------------------------
module bmp32pm_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  bmp32pm_pkg::job_t      q_job,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output bmp32pm_pkg::out_word_t out_word
);

  logic                   out_valid_r, out_valid_nxt;
  bmp32pm_pkg::out_word_t out_word_r, out_word_nxt;

  // Advance whenever the output register is empty or being drained
  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_word_nxt           = out_word_r;
    out_valid_nxt          = out_valid_r && out_stall;
    if (q_pop) begin
      out_valid_nxt          = 1'b1;
      out_word_nxt.kind      = q_job.kind;
      out_word_nxt.chan0     = bmp32pm_pkg::premul(q_job.raw0, q_job.alpha);
      out_word_nxt.chan1     = bmp32pm_pkg::premul(q_job.raw1, q_job.alpha);
      out_word_nxt.chan2     = bmp32pm_pkg::premul(q_job.raw2, q_job.alpha);
      out_word_nxt.alpha_out = q_job.alpha;
      out_word_nxt.dest_row  = q_job.dest_row;
      out_word_nxt.dest_col  = q_job.dest_col;
      out_word_nxt.last      = q_job.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Error words carry nothing but their kind
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.kind != bmp32pm_pkg::KIND_PIXEL |->
    out_word_r.chan0 == '0 && out_word_r.chan1 == '0 && out_word_r.chan2 == '0 &&
    out_word_r.alpha_out == '0 && out_word_r.last == 1'b0)
    else $error("error word with nonzero payload");

  // Premultiplied channels never exceed alpha
  a_chan_le_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_word_r.chan0 <= out_word_r.alpha_out &&
    out_word_r.chan1 <= out_word_r.alpha_out && out_word_r.chan2 <= out_word_r.alpha_out)
    else $error("premultiplied channel above alpha");

endmodule
